// File: design/ipvr_pkg.sv
// Shared constants for the inverse Park voltage rotation block.
// Sine polynomial coefficients, fixed Q30 widths and pipeline depths.
// No dependencies; imported by every module of the block.
package ipvr_pkg;

    // Phase word inside the sine unit: full turn = 2^32
    localparam int PH_W = 32;
    // Signed Q2.30 sine / cosine
    localparam int SIN_W = 32;
    // Folded angle magnitude, up to one quarter turn (2^30)
    localparam int X_W = 31;
    // Width of every polynomial product
    localparam int PROD_W = 2 * X_W;
    // Fraction bits of the trigonometric values
    localparam int Q_SHIFT = 30;

    // Widths of the Horner partial terms, each just holds its coefficient
    localparam int T7_W = 23;
    localparam int T5_W = 27;
    localparam int T3_W = 30;
    localparam int T1_W = 31;
    localparam int C9_W = 18;

    // Odd Taylor coefficients of sin(x * pi/2) in Q30
    localparam logic [T1_W-1:0] SIN_C1 = T1_W'(1686629713);
    localparam logic [T3_W-1:0] SIN_C3 = T3_W'(693598667);
    localparam logic [T5_W-1:0] SIN_C5 = T5_W'(85569364);
    localparam logic [T7_W-1:0] SIN_C7 = T7_W'(5026995);
    localparam logic [C9_W-1:0] SIN_C9 = C9_W'(172272);

    // One in Q30, and the quarter turn of the phase word
    localparam logic [X_W-1:0]  Q30_ONE      = X_W'(32'h4000_0000);
    localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // Pipeline depths: sine unit and rotation unit
    localparam int SIN_STAGES = 7;
    localparam int ROT_STAGES = 2;

endpackage

// File: design/ipvr_sin_pipe.sv
// Pipelined Q30 sine of a 32-bit phase word (degree-9 odd polynomial).
// Seven register stages, one multiplier in each stage after the first. Depends on ipvr_pkg.
module ipvr_sin_pipe
    import ipvr_pkg::*;
(
    input  logic                    clk,
    input  logic [PH_W-1:0]         phase,
    output logic signed [SIN_W-1:0] sin_q30
);

    localparam logic signed [PH_W:0] FOLD_LIMIT = (PH_W+1)'(64'sd1073741824);
    localparam logic signed [PH_W:0] HALF_TURN  = (PH_W+1)'(64'sd2147483648);

    logic signed [PH_W:0]  ang_s;
    logic signed [PH_W:0]  ang_fold;
    logic                  neg_next;
    logic [X_W-1:0]        x_next;
    logic [PROD_W-1:0]     prod_sq;
    logic [PROD_W-1:0]     prod_t7;
    logic [PROD_W-1:0]     prod_t5;
    logic [PROD_W-1:0]     prod_t3;
    logic [PROD_W-1:0]     prod_t1;
    logic [PROD_W-1:0]     prod_y;
    logic [X_W-1:0]        sq_next;
    logic [T7_W-1:0]       t7_next;
    logic [T5_W-1:0]       t5_next;
    logic [T3_W-1:0]       t3_next;
    logic [T1_W-1:0]       t1_next;
    logic [SIN_W-1:0]      y_raw;
    logic [X_W-1:0]        y_mag;
    logic signed [SIN_W-1:0] sin_next;

    logic [X_W-1:0]        x_reg   [1:6];
    logic                  neg_reg [1:6];
    logic [X_W-1:0]        sq_reg  [2:5];
    logic [T7_W-1:0]       t7_reg;
    logic [T5_W-1:0]       t5_reg;
    logic [T3_W-1:0]       t3_reg;
    logic [T1_W-1:0]       t1_reg;
    logic signed [SIN_W-1:0] sin_reg;

    // Stage 1: fold the angle into [-pi/2, pi/2], split sign and magnitude
    always_comb
    begin
        ang_s = $signed({phase[PH_W-1], phase});
        if (ang_s > FOLD_LIMIT)
        begin
            ang_fold = HALF_TURN - ang_s;
        end
        else if (ang_s < -FOLD_LIMIT)
        begin
            ang_fold = -HALF_TURN - ang_s;
        end
        else
        begin
            ang_fold = ang_s;
        end
        neg_next = ang_fold[PH_W];
        x_next   = neg_next ? X_W'(-ang_fold) : X_W'(ang_fold);
    end

    // Stage 2: square of the folded angle
    assign prod_sq = PROD_W'(x_reg[1]) * PROD_W'(x_reg[1]);
    assign sq_next = prod_sq[Q_SHIFT+X_W-1:Q_SHIFT];

    // Stages 3 to 6: Horner steps, one coefficient per stage
    assign prod_t7 = PROD_W'(sq_reg[2]) * PROD_W'(SIN_C9);
    assign t7_next = T7_W'(PROD_W'(SIN_C7) - (prod_t7 >> Q_SHIFT));

    assign prod_t5 = PROD_W'(sq_reg[3]) * PROD_W'(t7_reg);
    assign t5_next = T5_W'(PROD_W'(SIN_C5) - (prod_t5 >> Q_SHIFT));

    assign prod_t3 = PROD_W'(sq_reg[4]) * PROD_W'(t5_reg);
    assign t3_next = T3_W'(PROD_W'(SIN_C3) - (prod_t3 >> Q_SHIFT));

    assign prod_t1 = PROD_W'(sq_reg[5]) * PROD_W'(t3_reg);
    assign t1_next = T1_W'(PROD_W'(SIN_C1) - (prod_t1 >> Q_SHIFT));

    // Stage 7: final multiply by x, clamp to one, restore sign
    assign prod_y = PROD_W'(x_reg[6]) * PROD_W'(t1_reg);
    assign y_raw  = prod_y[Q_SHIFT+SIN_W-1:Q_SHIFT];

    always_comb
    begin
        if (y_raw > SIN_W'(Q30_ONE))
        begin
            y_mag = Q30_ONE;
        end
        else
        begin
            y_mag = y_raw[X_W-1:0];
        end
        sin_next = neg_reg[6] ? -$signed(SIN_W'(y_mag)) : $signed(SIN_W'(y_mag));
    end

    // Pipeline registers (payload only, no reset)
    always_ff @(posedge clk)
    begin
        x_reg[1]   <= x_next;
        neg_reg[1] <= neg_next;
        for (int i = 2; i <= 6; i++)
        begin
            x_reg[i]   <= x_reg[i-1];
            neg_reg[i] <= neg_reg[i-1];
        end
        sq_reg[2] <= sq_next;
        for (int i = 3; i <= 5; i++)
        begin
            sq_reg[i] <= sq_reg[i-1];
        end
        t7_reg  <= t7_next;
        t5_reg  <= t5_next;
        t3_reg  <= t3_next;
        t1_reg  <= t1_next;
        sin_reg <= sin_next;
    end

    assign sin_q30 = sin_reg;

endmodule

// File: design/ipvr_rotate.sv
// Rotation of the saturated d/q pair by a Q30 sine/cosine pair.
// Products in one stage, sum and round-half-away in the next. Uses ipvr_pkg.
module ipvr_rotate
    import ipvr_pkg::*;
#(
    parameter int VOLT_FRAC_BITS = 12
)
(
    input  logic                            clk,
    input  logic signed [VOLT_FRAC_BITS+1:0] d_in,
    input  logic signed [VOLT_FRAC_BITS+1:0] q_in,
    input  logic signed [SIN_W-1:0]          sin_in,
    input  logic signed [SIN_W-1:0]          cos_in,
    output logic signed [VOLT_FRAC_BITS+1:0] alpha,
    output logic signed [VOLT_FRAC_BITS+1:0] beta
);

    localparam int OUT_W = VOLT_FRAC_BITS + 2;
    localparam int PW    = OUT_W + SIN_W;
    localparam int AW    = PW + 1;
    localparam logic [AW-1:0] ROUND_HALF = AW'(1) << (Q_SHIFT - 1);

    logic signed [PW-1:0] p_dc_reg;
    logic signed [PW-1:0] p_qs_reg;
    logic signed [PW-1:0] p_ds_reg;
    logic signed [PW-1:0] p_qc_reg;
    logic signed [AW-1:0] acc_a;
    logic signed [AW-1:0] acc_b;
    logic [AW-1:0]        rnd_a;
    logic [AW-1:0]        rnd_b;
    logic [OUT_W-1:0]     alpha_next;
    logic [OUT_W-1:0]     beta_next;
    logic [OUT_W-1:0]     alpha_reg;
    logic [OUT_W-1:0]     beta_reg;

    // Stage 1: the four products
    always_ff @(posedge clk)
    begin
        p_dc_reg <= PW'(d_in) * PW'(cos_in);
        p_qs_reg <= PW'(q_in) * PW'(sin_in);
        p_ds_reg <= PW'(d_in) * PW'(sin_in);
        p_qc_reg <= PW'(q_in) * PW'(cos_in);
    end

    // Stage 2: sums, round to nearest with ties away from zero.
    // Negative sums add half minus one before the arithmetic shift.
    always_comb
    begin
        acc_a      = AW'(p_dc_reg) - AW'(p_qs_reg);
        acc_b      = AW'(p_ds_reg) + AW'(p_qc_reg);
        rnd_a      = acc_a + ROUND_HALF - AW'(acc_a[AW-1]);
        rnd_b      = acc_b + ROUND_HALF - AW'(acc_b[AW-1]);
        alpha_next = rnd_a[Q_SHIFT+OUT_W-1:Q_SHIFT];
        beta_next  = rnd_b[Q_SHIFT+OUT_W-1:Q_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
        beta_reg  <= beta_next;
    end

    assign alpha = $signed(alpha_reg);
    assign beta  = $signed(beta_reg);

endmodule

// File: design/inverse_park_voltage_rotate.sv
// Inverse Park transform: rotates a d/q voltage pair into alpha/beta.
// Top level; instantiates ipvr_sin_pipe (twice) and ipvr_rotate, uses ipvr_pkg.
//
// Usage
//   Command port: an item (d_voltage, q_voltage, phase_word) is taken at a
//   rising edge where start is high and busy is low. busy is high only while
//   reset is applied and for the first edge after it; afterwards an item may
//   be started on every cycle.
//   Result port: alpha_voltage and beta_voltage are valid for exactly one
//   cycle while done is high. The receiver cannot stall the block.
// Timing
//   done rises after the item has passed one input register, seven
//   stages of the sine polynomial (a multiplier in each but the first)
//   and two stages of rotation (products, then sum and rounding).
//   Throughput is one item per cycle; items leave in the order they came.
// Reset
//   rst_n clears the pipeline valid bits and sets busy, so no done pulse
//   follows reset. The data registers are not reset.
module inverse_park_voltage_rotate
    import ipvr_pkg::*;
#(
    parameter int ANGLE_BITS     = 16,
    parameter int VOLT_FRAC_BITS = 12
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [VOLT_FRAC_BITS+3:0] d_voltage,
    input  logic signed [VOLT_FRAC_BITS+3:0] q_voltage,
    input  logic [ANGLE_BITS-1:0]            phase_word,
    output logic                             done,
    output logic signed [VOLT_FRAC_BITS+1:0] alpha_voltage,
    output logic signed [VOLT_FRAC_BITS+1:0] beta_voltage
);

    localparam int IN_W    = VOLT_FRAC_BITS + 4;
    localparam int SAT_W   = VOLT_FRAC_BITS + 2;
    localparam int LATENCY = 1 + SIN_STAGES + ROT_STAGES;
    localparam logic signed [IN_W-1:0]  V_ONE     = IN_W'(1) << VOLT_FRAC_BITS;
    localparam logic signed [SAT_W-1:0] OUT_BOUND = SAT_W'(3) << (VOLT_FRAC_BITS - 1);
    localparam logic signed [SIN_W-1:0] SIN_ONE   = SIN_W'(Q30_ONE);

    function automatic logic signed [SAT_W-1:0] sat_one(input logic signed [IN_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        if (v > V_ONE)
        begin
            r = SAT_W'(V_ONE);
        end
        else if (v < -V_ONE)
        begin
            r = SAT_W'(-V_ONE);
        end
        else
        begin
            r = SAT_W'(v);
        end
        return r;
    endfunction

    logic                    accept;
    logic                    busy_reg;
    logic [LATENCY-1:0]      valid_reg;
    logic [PH_W-1:0]         ph_lift;
    logic signed [SAT_W-1:0] d_sat_reg;
    logic signed [SAT_W-1:0] q_sat_reg;
    logic [PH_W-1:0]         sin_ph_reg;
    logic [PH_W-1:0]         cos_ph_reg;
    logic signed [SAT_W-1:0] d_dly_reg [1:SIN_STAGES];
    logic signed [SAT_W-1:0] q_dly_reg [1:SIN_STAGES];
    logic signed [SIN_W-1:0] sin_val;
    logic signed [SIN_W-1:0] cos_val;

    assign accept = start && !busy_reg;

    // Control: busy held over reset, valid bits track items down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= '0;
        end
        else
        begin
            busy_reg  <= 1'b0;
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
        end
    end

    // Input register: saturated voltages, phase lifted to a 32-bit turn
    assign ph_lift = PH_W'(phase_word) << (PH_W - ANGLE_BITS);

    always_ff @(posedge clk)
    begin
        d_sat_reg  <= sat_one(d_voltage);
        q_sat_reg  <= sat_one(q_voltage);
        sin_ph_reg <= ph_lift;
        cos_ph_reg <= ph_lift + QUARTER_TURN;
    end

    // Delay line keeping d/q aligned with the sine unit
    always_ff @(posedge clk)
    begin
        d_dly_reg[1] <= d_sat_reg;
        q_dly_reg[1] <= q_sat_reg;
        for (int i = 2; i <= SIN_STAGES; i++)
        begin
            d_dly_reg[i] <= d_dly_reg[i-1];
            q_dly_reg[i] <= q_dly_reg[i-1];
        end
    end

    ipvr_sin_pipe u_sin
    (
        .clk     (clk),
        .phase   (sin_ph_reg),
        .sin_q30 (sin_val)
    );

    ipvr_sin_pipe u_cos
    (
        .clk     (clk),
        .phase   (cos_ph_reg),
        .sin_q30 (cos_val)
    );

    ipvr_rotate #(
        .VOLT_FRAC_BITS (VOLT_FRAC_BITS)
    ) u_rotate
    (
        .clk    (clk),
        .d_in   (d_dly_reg[SIN_STAGES]),
        .q_in   (q_dly_reg[SIN_STAGES]),
        .sin_in (sin_val),
        .cos_in (cos_val),
        .alpha  (alpha_voltage),
        .beta   (beta_voltage)
    );

    assign busy = busy_reg;
    assign done = valid_reg[LATENCY-1];

    // Every item taken comes out after the fixed pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("item did not complete after pipeline latency");

    // Sine and cosine stay within plus or minus one
    a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[SIN_STAGES] |-> (sin_val <= SIN_ONE) && (sin_val >= -SIN_ONE))
        else $error("sine out of range");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[SIN_STAGES] |-> (cos_val <= SIN_ONE) && (cos_val >= -SIN_ONE))
        else $error("cosine out of range");

    // Each component of a rotated saturated vector stays within plus or minus 1.5
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (alpha_voltage <= OUT_BOUND) && (alpha_voltage >= -OUT_BOUND)
              && (beta_voltage <= OUT_BOUND) && (beta_voltage >= -OUT_BOUND))
        else $error("alpha/beta out of range");

endmodule
